// ----- hw/rtl/pnq_pkg.sv -----
// pnq_pkg: shared types, codes and constants of the pitch error / note quantizer.
// Used by pnq_norm, pnq_search and the top level pitch_error_note_quantizer.
// No dependencies.
`default_nettype none

package pnq_pkg;

   // datapath sizes
   localparam int NUM_NOTES = 12;
   localparam int FRAC_W    = 16;     // log2 fraction bits, one octave = 2^16
   localparam int MANT_W    = 32;     // Q1.31 mantissa
   localparam int NORM_W    = 36;     // holds period * ref_pitch (35 bits)
   localparam int NORM_STEPS = 6;     // shift by 32, 16, 8, 4, 2, 1
   localparam int ERR_W     = 18;
   localparam int SUM_W     = 22;     // error plus filter step before saturation
   localparam int PROD_W    = 36;     // signed filter product

   localparam logic [3:0] NO_NOTE = 4'd12;
   localparam logic [3:0] LAST_NOTE_IDX = 4'd11;
   localparam logic [3:0] LAST_SQUARE = 4'd15;
   localparam logic [3:0] LAST_NORM = 4'd5;

   localparam logic signed [SUM_W-1:0] ERR_MAX = 22'sd65536;
   localparam logic signed [SUM_W-1:0] ERR_MIN = -22'sd65536;
   localparam logic signed [ERR_W-1:0] DIST_INIT = 18'sd65536;

   // input word kinds
   typedef enum logic [1:0] {
      FUNC_PERIOD = 2'd0,
      FUNC_FORGET = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // register indexes
   typedef enum logic [2:0] {
      REG_SAMPLE_RATE = 3'd0,
      REG_REF_PITCH   = 3'd1,
      REG_ALLOWED     = 3'd2,
      REG_HOLD_BIAS   = 3'd3,
      REG_SMOOTHING   = 3'd4
   } reg_index_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM_A,
      ST_LOG_A,
      ST_PROD,
      ST_NORM_B,
      ST_LOG_B,
      ST_SEARCH,
      ST_FILT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic [2:0] idx;
   } norm_ctrl_type;

   typedef struct packed {
      logic       clear;
      logic       step;
      logic [3:0] idx;
   } search_ctrl_type;

   typedef struct packed {
      logic signed [FRAC_W-1:0] dm;
      logic [3:0]               im;
   } pick_type;

   // Note offsets (i - 9) / 12 octave, rounded, kept modulo one octave
   // since only the fractional part of the pitch enters the distance.
   function automatic logic [FRAC_W-1:0] note_offset(input logic [3:0] idx);
      logic [FRAC_W-1:0] r;
      case (idx)
         4'd0:    r = 16'h4000;
         4'd1:    r = 16'h5555;
         4'd2:    r = 16'h6AAB;
         4'd3:    r = 16'h8000;
         4'd4:    r = 16'h9555;
         4'd5:    r = 16'hAAAB;
         4'd6:    r = 16'hC000;
         4'd7:    r = 16'hD555;
         4'd8:    r = 16'hEAAB;
         4'd9:    r = 16'h0000;
         4'd10:   r = 16'h1555;
         4'd11:   r = 16'h2AAB;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pnq_mult.sv -----
// pnq_mult: shared 32x32 unsigned multiplier of the quantizer.
// Serves the log squarings, period * ref_pitch and the error filter. No package use.
`default_nettype none

module pnq_mult (
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] product
);

   // one full product; every consumer registers it
   assign product = op_a * op_b;

endmodule

`default_nettype wire

// ----- hw/rtl/pnq_norm.sv -----
// pnq_norm: normalizer for the log unit, moves the leading one to the top bit
// in six binary steps. Depends on pnq_pkg.
`default_nettype none

module pnq_norm (
   input  wire logic                         clock,
   input  wire pnq_pkg::norm_ctrl_type       ctrl,
   input  wire logic [pnq_pkg::NORM_W-1:0]   load_value,
   output logic      [pnq_pkg::MANT_W-1:0]   mant
);

   logic [pnq_pkg::NORM_W-1:0] nv_ff, nv_in;

   // one shift step: shift when the top bits are all zero
   always_comb begin
      nv_in = nv_ff;
      if (ctrl.load) begin
         nv_in = load_value;
      end else if (ctrl.step) begin
         case (ctrl.idx)
            3'd0: if (nv_ff[35:4] == '0)  nv_in = {nv_ff[3:0], 32'b0};
            3'd1: if (nv_ff[35:20] == '0) nv_in = {nv_ff[19:0], 16'b0};
            3'd2: if (nv_ff[35:28] == '0) nv_in = {nv_ff[27:0], 8'b0};
            3'd3: if (nv_ff[35:32] == '0) nv_in = {nv_ff[31:0], 4'b0};
            3'd4: if (nv_ff[35:34] == '0) nv_in = {nv_ff[33:0], 2'b0};
            3'd5: if (!nv_ff[35])         nv_in = {nv_ff[34:0], 1'b0};
            default: nv_in = nv_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      nv_ff <= nv_in;
   end

   // Q1.31 mantissa, truncated
   assign mant = nv_ff[pnq_pkg::NORM_W-1 -: pnq_pkg::MANT_W];

endmodule

`default_nettype wire

// ----- hw/rtl/pnq_search.sv -----
// pnq_search: nearest allowed note search, one semitone per cycle, with the
// hold bias for the previous note. Depends on pnq_pkg.
`default_nettype none

module pnq_search (
   input  wire logic                          clock,
   input  wire pnq_pkg::search_ctrl_type      ctrl,
   input  wire logic [pnq_pkg::FRAC_W-1:0]    pitch_frac,
   input  wire logic [11:0]                   allowed,
   input  wire logic [3:0]                    last_note,
   input  wire logic [15:0]                   hold_bias,
   output pnq_pkg::pick_type                  pick
);

   logic signed [pnq_pkg::ERR_W-1:0] best_ff, best_in;
   pnq_pkg::pick_type                pick_ff, pick_in;

   logic [pnq_pkg::FRAC_W-1:0]       note_delta;
   logic [pnq_pkg::FRAC_W:0]         dist_ext;
   logic [pnq_pkg::FRAC_W:0]         dist_abs;
   logic signed [pnq_pkg::ERR_W-1:0] dist_bias;
   logic                             closer;

   // signed distance to the note, folded into half an octave
   always_comb begin
      note_delta = pitch_frac - pnq_pkg::note_offset(ctrl.idx);
      dist_ext   = {note_delta[pnq_pkg::FRAC_W-1], note_delta};
      dist_abs   = dist_ext[pnq_pkg::FRAC_W] ? (~dist_ext + 1'b1) : dist_ext;
      dist_bias  = $signed({1'b0, dist_abs});
      if (ctrl.idx == last_note) begin
         dist_bias = $signed({1'b0, dist_abs}) - $signed({2'b0, hold_bias});
      end
      closer = allowed[ctrl.idx] && (dist_bias < best_ff);
   end

   // running minimum, strict compare keeps the lower index on ties
   always_comb begin
      best_in = best_ff;
      pick_in = pick_ff;
      if (ctrl.clear) begin
         best_in    = pnq_pkg::DIST_INIT;
         pick_in.dm = '0;
         pick_in.im = pnq_pkg::NO_NOTE;
      end else if (ctrl.step && closer) begin
         best_in    = dist_bias;
         pick_in.dm = $signed(note_delta);
         pick_in.im = ctrl.idx;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      pick_ff <= pick_in;
   end

   assign pick = pick_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/pitch_error_note_quantizer.sv -----
// pitch_error_note_quantizer: top level, sequencer and state of the note quantizer.
// Depends on pnq_pkg, pnq_mult, pnq_norm and pnq_search.
//
//   channel  | ports     | dir | word contents
//   request  | req_*     | in  | tuser: func[1:0]; tdata: cycle_period[19:0]
//   result   | rsp_*     | out | tdata: pitch_error[17:0], chosen_note[21:18], notes_seen[33:22]
//   control  | csr_*     | in  | five registers at byte addresses 0, 4, 8, 12, 16
//
// A period word (func 0, some note allowed) runs from acceptance to a valid result through
// two log2 evaluations of 6 normalize steps and 16 squarings each, all squarings on the
// one shared 32x32 multiplier, then a note search over the 12 semitones and the error filter.
// Other words go straight to the final update. One word is in work at a time.
// A result waiting on rsp_tready stalls only the final update; a new word is accepted
// as soon as the previous one is finished. Reset is synchronous; no clearing pass.
`default_nettype none

module pitch_error_note_quantizer (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // cycle_period[19:0], zero pad
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // pitch_error[17:0], chosen_note[21:18],
                                         // notes_seen[33:22], zero pad
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   // registers
   logic [17:0] sample_rate_ff;
   logic [14:0] ref_pitch_ff;
   logic [11:0] allowed_ff;
   logic [15:0] hold_bias_ff;
   logic [16:0] smoothing_ff;

   // block state
   logic [3:0]                       last_ff, last_in;
   logic signed [pnq_pkg::ERR_W-1:0] err_ff, err_in;
   logic [11:0]                      seen_ff, seen_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // sequencer
   pnq_pkg::state_type state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;

   // working registers
   pnq_pkg::func_type                func_ff;
   logic [19:0]                      period_ff;
   logic [pnq_pkg::MANT_W-1:0]       m_ff, m_in;
   logic [pnq_pkg::FRAC_W-1:0]       frac_ff, frac_in;
   logic [pnq_pkg::FRAC_W-1:0]       fa_ff;
   logic [pnq_pkg::FRAC_W-1:0]       f_ff;
   logic signed [pnq_pkg::PROD_W-1:0] prod_ff, prod_in;

   // control and datapath nets
   logic                        accept;
   logic                        done_fire;
   logic                        csr_write;
   pnq_pkg::norm_ctrl_type      norm_ctrl;
   pnq_pkg::search_ctrl_type    search_ctrl;
   pnq_pkg::pick_type           pick;
   logic [pnq_pkg::NORM_W-1:0]  norm_value;
   logic [pnq_pkg::MANT_W-1:0]  norm_mant;
   logic [pnq_pkg::MANT_W-1:0]  sq_src;
   logic [31:0]                 mul_a, mul_b;
   logic [63:0]                 mul_p;
   logic [32:0]                 sq_top;
   logic [17:0]                 rate_nz;
   logic [14:0]                 ref_nz;
   logic [19:0]                 period_nz;
   logic signed [18:0]          diff;
   logic [18:0]                 diff_mag;
   logic [pnq_pkg::PROD_W:0]    rnd_sum;
   logic signed [pnq_pkg::SUM_W-1:0] err_sum;
   logic signed [pnq_pkg::ERR_W-1:0] err_sat;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= 18'd48000;
         ref_pitch_ff   <= 15'd28160;
         allowed_ff     <= 12'hFFF;
         hold_bias_ff   <= 16'd0;
         smoothing_ff   <= 17'd65536;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            pnq_pkg::REG_SAMPLE_RATE: sample_rate_ff <= csr_pwdata[17:0];
            pnq_pkg::REG_REF_PITCH:   ref_pitch_ff   <= csr_pwdata[14:0];
            pnq_pkg::REG_ALLOWED:     allowed_ff     <= csr_pwdata[11:0];
            pnq_pkg::REG_HOLD_BIAS:   hold_bias_ff   <= csr_pwdata[15:0];
            pnq_pkg::REG_SMOOTHING:   smoothing_ff   <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         pnq_pkg::REG_SAMPLE_RATE: csr_prdata = {14'b0, sample_rate_ff};
         pnq_pkg::REG_REF_PITCH:   csr_prdata = {17'b0, ref_pitch_ff};
         pnq_pkg::REG_ALLOWED:     csr_prdata = {20'b0, allowed_ff};
         pnq_pkg::REG_HOLD_BIAS:   csr_prdata = {16'b0, hold_bias_ff};
         pnq_pkg::REG_SMOOTHING:   csr_prdata = {15'b0, smoothing_ff};
         default:                  csr_prdata = 32'b0;
      endcase
   end

   // zero operands count as one
   assign rate_nz   = (sample_rate_ff == '0) ? 18'd1 : sample_rate_ff;
   assign ref_nz    = (ref_pitch_ff == '0) ? 15'd1 : ref_pitch_ff;
   assign period_nz = (period_ff == '0) ? 20'd1 : period_ff;

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         pnq_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               if (pnq_pkg::func_type'(req_tuser) == pnq_pkg::FUNC_PERIOD && allowed_ff != '0)
                  state_in = pnq_pkg::ST_NORM_A;
               else
                  state_in = pnq_pkg::ST_DONE;
            end
         end
         pnq_pkg::ST_NORM_A, pnq_pkg::ST_NORM_B: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == pnq_pkg::LAST_NORM) begin
               cnt_in   = '0;
               state_in = (state_ff == pnq_pkg::ST_NORM_A) ? pnq_pkg::ST_LOG_A
                                                           : pnq_pkg::ST_LOG_B;
            end
         end
         pnq_pkg::ST_LOG_A, pnq_pkg::ST_LOG_B: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == pnq_pkg::LAST_SQUARE) begin
               cnt_in   = '0;
               state_in = (state_ff == pnq_pkg::ST_LOG_A) ? pnq_pkg::ST_PROD
                                                          : pnq_pkg::ST_SEARCH;
            end
         end
         pnq_pkg::ST_PROD: begin
            cnt_in   = '0;
            state_in = pnq_pkg::ST_NORM_B;
         end
         pnq_pkg::ST_SEARCH: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == pnq_pkg::LAST_NOTE_IDX) begin
               cnt_in   = '0;
               state_in = pnq_pkg::ST_FILT;
            end
         end
         pnq_pkg::ST_FILT: state_in = pnq_pkg::ST_DONE;
         pnq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = pnq_pkg::ST_IDLE;
         end
         default: state_in = pnq_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_tready        = 1'b0;
      done_fire         = 1'b0;
      norm_ctrl         = '0;
      search_ctrl       = '0;
      norm_value        = {4'b0, rate_nz, 14'b0};
      mul_a             = '0;
      mul_b             = '0;
      norm_ctrl.idx     = cnt_ff[2:0];
      search_ctrl.idx   = cnt_ff;
      case (state_ff)
         pnq_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            norm_ctrl.load = req_tvalid;
         end
         pnq_pkg::ST_NORM_A, pnq_pkg::ST_NORM_B: norm_ctrl.step = 1'b1;
         pnq_pkg::ST_LOG_A, pnq_pkg::ST_LOG_B: begin
            mul_a = sq_src;
            mul_b = sq_src;
         end
         pnq_pkg::ST_PROD: begin
            mul_a             = {12'b0, period_nz};
            mul_b             = {17'b0, ref_nz};
            norm_ctrl.load    = 1'b1;
            norm_value        = mul_p[pnq_pkg::NORM_W-1:0];
            search_ctrl.clear = 1'b1;
         end
         pnq_pkg::ST_SEARCH: search_ctrl.step = 1'b1;
         pnq_pkg::ST_FILT: begin
            mul_a = {15'b0, smoothing_ff};
            mul_b = {13'b0, diff_mag};
         end
         pnq_pkg::ST_DONE: done_fire = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnq_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------- shared units ----------------
   pnq_mult u_mult (
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   pnq_norm u_norm (
      .clock      (clock),
      .ctrl       (norm_ctrl),
      .load_value (norm_value),
      .mant       (norm_mant)
   );

   pnq_search u_search (
      .clock      (clock),
      .ctrl       (search_ctrl),
      .pitch_frac (f_ff),
      .allowed    (allowed_ff),
      .last_note  (last_ff),
      .hold_bias  (hold_bias_ff),
      .pick       (pick)
   );

   // ---------------- log2 by repeated squaring ----------------
   // first square starts from the normalized mantissa
   assign sq_src = (cnt_ff == '0) ? norm_mant : m_ff;
   assign sq_top = mul_p[63:31];

   always_comb begin
      m_in    = m_ff;
      frac_in = frac_ff;
      if (state_ff == pnq_pkg::ST_LOG_A || state_ff == pnq_pkg::ST_LOG_B) begin
         m_in    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
         frac_in = {frac_ff[pnq_pkg::FRAC_W-2:0], sq_top[32]};
      end
   end

   // ---------------- error filter ----------------
   assign diff     = 19'($signed(pick.dm)) - 19'(err_ff);
   assign diff_mag = diff[18] ? 19'(-diff) : 19'(diff);

   always_comb begin
      prod_in = $signed(mul_p[pnq_pkg::PROD_W-1:0]);
      if (diff[18]) prod_in = -$signed(mul_p[pnq_pkg::PROD_W-1:0]);
   end

   // round half up, then saturate
   assign rnd_sum = {prod_ff[pnq_pkg::PROD_W-1], prod_ff} + 37'd32768;
   assign err_sum = 22'(err_ff) + 22'($signed(rnd_sum[pnq_pkg::PROD_W:16]));

   always_comb begin
      if (err_sum > pnq_pkg::ERR_MAX)      err_sat = 18'(pnq_pkg::ERR_MAX);
      else if (err_sum < pnq_pkg::ERR_MIN) err_sat = 18'(pnq_pkg::ERR_MIN);
      else                                 err_sat = 18'(err_sum);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= pnq_pkg::func_type'(req_tuser);
         period_ff <= req_tdata[19:0];
      end
      m_ff    <= m_in;
      frac_ff <= frac_in;
      if (state_ff == pnq_pkg::ST_PROD) fa_ff <= frac_ff;
      if (state_ff == pnq_pkg::ST_LOG_B && cnt_ff == pnq_pkg::LAST_SQUARE)
         f_ff <= fa_ff - frac_in;
      if (state_ff == pnq_pkg::ST_FILT) prod_ff <= prod_in;
   end

   assign accept = req_tvalid && req_tready;

   // ---------------- state update and result ----------------
   always_comb begin
      last_in = last_ff;
      err_in  = err_ff;
      seen_in = seen_ff;
      if (done_fire) begin
         case (func_ff)
            pnq_pkg::FUNC_PERIOD: begin
               if (allowed_ff == '0) begin
                  err_in  = '0;
                  last_in = pnq_pkg::NO_NOTE;
               end else begin
                  if (pick.im == last_ff) begin
                     err_in = err_sat;
                  end else begin
                     err_in  = 18'(pick.dm);
                     last_in = pick.im;
                  end
                  seen_in = seen_ff | (12'd1 << pick.im);
               end
            end
            pnq_pkg::FUNC_FORGET: last_in = pnq_pkg::NO_NOTE;
            pnq_pkg::FUNC_CLEAR:  err_in  = '0;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire)       rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= pnq_pkg::NO_NOTE;
         err_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         err_ff       <= err_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // state only moves when the waiting word is taken, so it is the output word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, seen_ff, last_ff, err_ff};

`ifndef ASSERT_OFF
   a_last_range: assert property (@(posedge clock) disable iff (reset)
      last_ff <= pnq_pkg::NO_NOTE)
      else $error("last note out of range");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      (err_ff <= 18'sd65536) && (err_ff >= -18'sd65536))
      else $error("pitch error out of range");

   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((seen_ff & $past(seen_ff)) == $past(seen_ff)))
      else $error("seen mask lost a bit");

   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pnq_pkg::ST_SEARCH) |-> (cnt_ff <= pnq_pkg::LAST_NOTE_IDX))
      else $error("note search ran past the last semitone");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("state moved while a result word waited");
`endif

endmodule

`default_nettype wire
